// ===== rtl/usc_pkg.sv =====
package usc_pkg;

    localparam int MAX_LEN = 4096;
    localparam int POS_W   = 13;
    localparam int PORT_W  = 17;

    localparam logic [POS_W-1:0]  MAX_POS  = POS_W'(MAX_LEN);
    localparam logic [PORT_W-1:0] PORT_MAX = PORT_W'(65535);
    localparam logic [PORT_W-1:0] PORT_OVF = PORT_W'(65536);

    // Parser phases.
    localparam logic [3:0] PH_SCHEME      = 4'd0;
    localparam logic [3:0] PH_AFTER_COLON = 4'd1;
    localparam logic [3:0] PH_SLASH1      = 4'd2;
    localparam logic [3:0] PH_HSTART      = 4'd3;
    localparam logic [3:0] PH_HNAME       = 4'd4;
    localparam logic [3:0] PH_BRACKET     = 4'd5;
    localparam logic [3:0] PH_AFTER_BR    = 4'd6;
    localparam logic [3:0] PH_PORT        = 4'd7;
    localparam logic [3:0] PH_PATH        = 4'd8;
    localparam logic [3:0] PH_TAIL        = 4'd9;

    typedef enum logic [3:0] {
        CK_OTHER,
        CK_COLON,
        CK_SLASH,
        CK_QMARK,   // '?' or '#'
        CK_AT,
        CK_LBRACK,
        CK_RBRACK,
        CK_PCT,
        CK_SSYM     // '+', '-' or '.'
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic       alpha;
        logic       digit;
        logic       hex;
        logic       ctl;
        logic [3:0] dval;
        logic       last;
    } tok_t;

    typedef struct packed {
        logic [POS_W-1:0] path_len;
        logic [POS_W-1:0] path_offset;
        logic [POS_W-1:0] host_len;
        logic [POS_W-1:0] host_offset;
        logic             has_host;
        logic [POS_W-1:0] scheme_len;
        logic             url_valid;
    } res_t;

    localparam int RES_W  = $bits(res_t);
    localparam int DATA_W = ((RES_W + 7) / 8) * 8;

    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);

    function automatic tok_t classify(input logic [7:0] c, input logic last);
        tok_t t;
        t.alpha = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
        t.digit = (c >= 8'h30 && c <= 8'h39);
        t.hex   = t.digit || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
        t.ctl   = (c <= 8'h20) || (c == 8'h7f);
        t.dval  = c[3:0];
        t.last  = last;
        unique case (c)
            8'h3a:               t.kind = CK_COLON;
            8'h2f:               t.kind = CK_SLASH;
            8'h3f, 8'h23:        t.kind = CK_QMARK;
            8'h40:               t.kind = CK_AT;
            8'h5b:               t.kind = CK_LBRACK;
            8'h5d:               t.kind = CK_RBRACK;
            8'h25:               t.kind = CK_PCT;
            8'h2b, 8'h2d, 8'h2e: t.kind = CK_SSYM;
            default:             t.kind = CK_OTHER;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/usc_front.sv =====
module usc_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          q_full,
    output logic          q_push,
    output usc_pkg::tok_t q_tok
);

    // The byte is decoded on the way in so the parser only sees token flags.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_tok    = usc_pkg::classify(s_tdata, s_tlast);

endmodule

// ===== rtl/usc_fifo.sv =====
module usc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  usc_pkg::tok_t push_tok,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output usc_pkg::tok_t head_tok
);

    usc_pkg::tok_t                   mem_reg [usc_pkg::QDEPTH];
    logic [usc_pkg::QIDX_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [usc_pkg::QIDX_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [usc_pkg::QIDX_W:0]        count_reg, count_next;

    assign full       = (count_reg == (usc_pkg::QIDX_W+1)'(usc_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_tok   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (usc_pkg::QIDX_W+1)'(push) - (usc_pkg::QIDX_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (usc_pkg::QIDX_W+1)'(usc_pkg::QDEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/usc_back.sv =====
module usc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  usc_pkg::tok_t  head_tok,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output usc_pkg::res_t  m_res
);

    localparam int PW = usc_pkg::POS_W;

    logic [3:0]                 phase_reg, phase_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic [PW-1:0]              scheme_len_reg, scheme_len_next;
    logic [PW-1:0]              host_ofs_reg, host_ofs_next;
    logic [PW-1:0]              host_len_reg, host_len_next;
    logic [PW-1:0]              path_ofs_reg, path_ofs_next;
    logic [PW-1:0]              path_len_reg, path_len_next;
    logic [usc_pkg::PORT_W-1:0] port_val_reg, port_val_next;
    logic [2:0]                 port_dig_reg, port_dig_next;
    logic [1:0]                 pct_reg, pct_next;
    logic                       err_reg, err_next;
    logic                       fault_reg, fault_next;
    logic                       auth_reg, auth_next;

    logic                       out_valid_reg, out_valid_next;
    usc_pkg::res_t              out_res_reg, out_res_next;

    logic                       load;
    logic                       term;
    logic [19:0]                port_acc;
    usc_pkg::tok_t              t;

    assign t       = head_tok;
    assign pop     = head_valid && (!t.last || !out_valid_reg || m_ready);
    assign load    = pop && t.last;
    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;
    assign term    = (t.kind == usc_pkg::CK_SLASH) || (t.kind == usc_pkg::CK_QMARK);
    assign port_acc = {port_val_reg, 3'b000} + {2'b00, port_val_reg, 1'b0} + 20'(t.dval);

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        scheme_len_next = scheme_len_reg;
        host_ofs_next   = host_ofs_reg;
        host_len_next   = host_len_reg;
        path_ofs_next   = path_ofs_reg;
        path_len_next   = path_len_reg;
        port_val_next   = port_val_reg;
        port_dig_next   = port_dig_reg;
        pct_next        = pct_reg;
        err_next        = err_reg;
        fault_next      = fault_reg;
        auth_next       = auth_reg;
        out_res_next    = out_res_reg;
        out_valid_next  = m_ready ? 1'b0 : out_valid_reg;

        if (pop)
        begin
            // Octet rules: escapes take the next two bytes as hex digits.
            if (pct_reg != 2'd0)
            begin
                if (!t.hex)
                begin
                    err_next = 1'b1;
                end
                pct_next = pct_reg - 2'd1;
            end
            else
            begin
                if (t.ctl)
                begin
                    err_next = 1'b1;
                end
                if (t.kind == usc_pkg::CK_PCT)
                begin
                    pct_next = 2'd2;
                end
            end

            unique case (phase_reg)
                usc_pkg::PH_SCHEME:
                begin
                    if (pos_reg == '0)
                    begin
                        if (!t.alpha)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    else if (t.kind == usc_pkg::CK_COLON)
                    begin
                        scheme_len_next = pos_reg;
                        phase_next      = usc_pkg::PH_AFTER_COLON;
                    end
                    else if (!(t.alpha || t.digit || t.kind == usc_pkg::CK_SSYM))
                    begin
                        err_next = 1'b1;
                    end
                end
                usc_pkg::PH_AFTER_COLON:
                begin
                    path_ofs_next = pos_reg;
                    if (t.kind == usc_pkg::CK_SLASH)
                    begin
                        path_len_next = PW'(1);
                        phase_next    = usc_pkg::PH_SLASH1;
                    end
                    else if (t.kind == usc_pkg::CK_QMARK)
                    begin
                        path_len_next = '0;
                        phase_next    = usc_pkg::PH_TAIL;
                    end
                    else
                    begin
                        path_len_next = PW'(1);
                        phase_next    = usc_pkg::PH_PATH;
                    end
                end
                usc_pkg::PH_SLASH1:
                begin
                    if (t.kind == usc_pkg::CK_SLASH)
                    begin
                        auth_next       = 1'b1;
                        path_len_next   = '0;
                        host_ofs_next   = pos_reg + PW'(1);
                        host_len_next   = '0;
                        port_val_next   = '0;
                        port_dig_next   = '0;
                        fault_next      = 1'b0;
                        phase_next      = usc_pkg::PH_HSTART;
                    end
                    else if (t.kind == usc_pkg::CK_QMARK)
                    begin
                        phase_next = usc_pkg::PH_TAIL;
                    end
                    else
                    begin
                        path_len_next = path_len_reg + PW'(1);
                        phase_next    = usc_pkg::PH_PATH;
                    end
                end
                usc_pkg::PH_PATH:
                begin
                    if (t.kind == usc_pkg::CK_QMARK)
                    begin
                        phase_next = usc_pkg::PH_TAIL;
                    end
                    else
                    begin
                        path_len_next = path_len_reg + PW'(1);
                    end
                end
                usc_pkg::PH_TAIL:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    if (term)
                    begin
                        // The authority ends here; check what the host collected.
                        if (phase_reg == usc_pkg::PH_HSTART || phase_reg == usc_pkg::PH_BRACKET
                            || (phase_reg == usc_pkg::PH_PORT && port_dig_reg == 3'd0)
                            || fault_reg)
                        begin
                            err_next = 1'b1;
                        end
                        path_ofs_next = pos_reg;
                        if (t.kind == usc_pkg::CK_SLASH)
                        begin
                            path_len_next = PW'(1);
                            phase_next    = usc_pkg::PH_PATH;
                        end
                        else
                        begin
                            path_len_next = '0;
                            phase_next    = usc_pkg::PH_TAIL;
                        end
                    end
                    else if (t.kind == usc_pkg::CK_AT)
                    begin
                        // Everything so far was user info; the host starts over.
                        host_ofs_next   = pos_reg + PW'(1);
                        host_len_next   = '0;
                        port_val_next   = '0;
                        port_dig_next   = '0;
                        fault_next      = 1'b0;
                        phase_next      = usc_pkg::PH_HSTART;
                    end
                    else if (phase_reg == usc_pkg::PH_HSTART)
                    begin
                        if (t.kind == usc_pkg::CK_LBRACK)
                        begin
                            host_ofs_next   = pos_reg + PW'(1);
                            phase_next      = usc_pkg::PH_BRACKET;
                        end
                        else if (t.kind == usc_pkg::CK_COLON)
                        begin
                            fault_next = 1'b1;
                            phase_next = usc_pkg::PH_PORT;
                        end
                        else
                        begin
                            host_len_next = PW'(1);
                            phase_next    = usc_pkg::PH_HNAME;
                        end
                    end
                    else if (phase_reg == usc_pkg::PH_HNAME)
                    begin
                        if (t.kind == usc_pkg::CK_COLON)
                        begin
                            phase_next = usc_pkg::PH_PORT;
                        end
                        else
                        begin
                            host_len_next = host_len_reg + PW'(1);
                        end
                    end
                    else if (phase_reg == usc_pkg::PH_BRACKET)
                    begin
                        if (t.kind == usc_pkg::CK_RBRACK)
                        begin
                            if (host_len_reg == '0)
                            begin
                                fault_next = 1'b1;
                            end
                            phase_next = usc_pkg::PH_AFTER_BR;
                        end
                        else
                        begin
                            host_len_next = host_len_reg + PW'(1);
                        end
                    end
                    else if (phase_reg == usc_pkg::PH_AFTER_BR)
                    begin
                        if (t.kind == usc_pkg::CK_COLON)
                        begin
                            phase_next = usc_pkg::PH_PORT;
                        end
                        else
                        begin
                            fault_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (t.digit)
                        begin
                            if (port_dig_reg < 3'd7)
                            begin
                                port_dig_next = port_dig_reg + 3'd1;
                            end
                            if (port_acc > 20'(usc_pkg::PORT_MAX))
                            begin
                                port_val_next = usc_pkg::PORT_OVF;
                                fault_next    = 1'b1;
                            end
                            else
                            begin
                                port_val_next = port_acc[usc_pkg::PORT_W-1:0];
                            end
                        end
                        else
                        begin
                            fault_next = 1'b1;
                        end
                    end
                end
            endcase

            if (pos_reg <= usc_pkg::MAX_POS)
            begin
                pos_next = pos_reg + PW'(1);
            end

            if (t.last)
            begin
                if (pos_next > usc_pkg::MAX_POS || pct_next != 2'd0
                    || phase_next == usc_pkg::PH_SCHEME)
                begin
                    err_next = 1'b1;
                end
                if (phase_next == usc_pkg::PH_AFTER_COLON)
                begin
                    path_ofs_next = pos_next;
                    path_len_next = '0;
                end
                if (phase_next >= usc_pkg::PH_HSTART && phase_next <= usc_pkg::PH_PORT)
                begin
                    if (phase_next == usc_pkg::PH_HSTART || phase_next == usc_pkg::PH_BRACKET
                        || (phase_next == usc_pkg::PH_PORT && port_dig_next == 3'd0)
                        || fault_next)
                    begin
                        err_next = 1'b1;
                    end
                    path_ofs_next = pos_next;
                    path_len_next = '0;
                end
                if (!auth_next && path_len_next == '0)
                begin
                    err_next = 1'b1;
                end

                out_valid_next = 1'b1;
                out_res_next   = '0;
                if (!err_next)
                begin
                    out_res_next.url_valid   = 1'b1;
                    out_res_next.scheme_len  = scheme_len_next;
                    out_res_next.has_host    = auth_next;
                    out_res_next.host_offset = auth_next ? host_ofs_next : '0;
                    out_res_next.host_len    = auth_next ? host_len_next : '0;
                    out_res_next.path_offset = path_ofs_next;
                    out_res_next.path_len    = path_len_next;
                end

                // Back to the idle state for the next URL.
                phase_next      = usc_pkg::PH_SCHEME;
                pos_next        = '0;
                scheme_len_next = '0;
                host_ofs_next   = '0;
                host_len_next   = '0;
                path_ofs_next   = '0;
                path_len_next   = '0;
                port_val_next   = '0;
                port_dig_next   = '0;
                pct_next        = '0;
                err_next        = 1'b0;
                fault_next      = 1'b0;
                auth_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= usc_pkg::PH_SCHEME;
            pos_reg        <= '0;
            scheme_len_reg <= '0;
            host_ofs_reg   <= '0;
            host_len_reg   <= '0;
            path_ofs_reg   <= '0;
            path_len_reg   <= '0;
            port_val_reg   <= '0;
            port_dig_reg   <= '0;
            pct_reg        <= '0;
            err_reg        <= 1'b0;
            fault_reg      <= 1'b0;
            auth_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            scheme_len_reg <= scheme_len_next;
            host_ofs_reg   <= host_ofs_next;
            host_len_reg   <= host_len_next;
            path_ofs_reg   <= path_ofs_next;
            path_len_reg   <= path_len_next;
            port_val_reg   <= port_val_next;
            port_dig_reg   <= port_dig_next;
            pct_reg        <= pct_next;
            err_reg        <= err_next;
            fault_reg      <= fault_next;
            auth_reg       <= auth_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        pct_reg != 2'd3)
        else $error("escape countdown out of range");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (pos_reg == '0 && phase_reg == usc_pkg::PH_SCHEME && !err_reg))
        else $error("parser did not restart after the last byte");

    a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_ready) |-> !load)
        else $error("result overwritten before it was taken");

    a_valid_has_path: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.url_valid && !out_res_reg.has_host)
            |-> (out_res_reg.path_len != '0))
        else $error("valid URL without authority has an empty path");

endmodule

// ===== rtl/url_syntax_checker.sv =====
// Channel   Dir  Fields
// s_*       in   tdata[7:0] char_byte, tlast final_byte
// m_*       out  tdata: url_valid, scheme_len, has_host, host_offset, host_len,
//                path_offset, path_len (from bit 0 up, zero-filled to 72 bits)
//
// One byte per cycle is sustained while the queue has room; the parser finishes each
// byte in the cycle it leaves the four-word queue, and each result is registered.
// Reset clears the queue and the parser state; the result register holds no word.
// A stalled result only holds back last bytes; other bytes keep flowing through
// the parser, and the queue holds input while the parser waits.
module url_syntax_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // char_byte
    input  logic                       s_tlast,   // final_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [usc_pkg::DATA_W-1:0] m_tdata    // url_valid, scheme_len, has_host,
                                                  // host_offset, host_len,
                                                  // path_offset, path_len
);

    logic          q_full;
    logic          q_push;
    usc_pkg::tok_t q_tok;
    logic          q_pop;
    logic          q_valid;
    usc_pkg::tok_t q_head;
    usc_pkg::res_t res;

    usc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_tok    (q_tok)
    );

    usc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_tok   (q_tok),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_tok   (q_head)
    );

    usc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_tok   (q_head),
        .pop        (q_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (res)
    );

    assign m_tdata = {(usc_pkg::DATA_W - usc_pkg::RES_W)'(0), res};

endmodule
